@@ sv/optt_pkg.sv @@
package optt_pkg;

  localparam int unsigned FuncW = 2;
  localparam int unsigned KindW = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_FRAME  = 2'd3
  } func_t;

  typedef enum logic [KindW-1:0] {
    K_ADDED    = 3'd0,
    K_FULL     = 3'd1,
    K_FIRED    = 3'd2,
    K_REMOVED  = 3'd3,
    K_NOTFOUND = 3'd4,
    K_CLEARED  = 3'd5,
    K_DONE     = 3'd6
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic  load;      // capture the input transaction, reset the slot index
    logic  rd;        // unused; the RAM always reads the current slot
    logic  step;      // advance the slot index
    logic  do_add;    // write the new timer into the current slot
    logic  do_free;   // drop the valid bit of the current slot
    logic  do_fire;   // record now in the current slot
    logic  do_clear;  // drop every valid bit
    logic  emit;      // load the output register
    kind_t kind;
    logic  id_sel;    // 0: zero id, 1: id from datapath
    logic  fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t func;
    logic  cur_valid;
    logic  match;     // removal id matches the slot that was read
    logic  due;       // slot that was read has expired
    logic  once;      // slot that was read is one-shot
    logic  at_end;    // current index is the last slot
    logic  out_busy;
  } sts_t;

endpackage

@@ sv/optt_ram.sv @@
module optt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/optt_datapath.sv @@
module optt_datapath
  import optt_pkg::*;
#(
  parameter int unsigned TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [98:0] in_word,
  output logic [39:0] out_word,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam int unsigned IdxW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned MemW = 97;  // one_shot, id, delay, last time

  logic [TASKS-1:0] valid_r, valid_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  func_t            func_r;
  logic [31:0]      now_r, dly_r, hid_r, next_id_r, next_id_nxt;
  logic             once_r;
  logic [39:0]      obuf_r;
  logic             ovld_r, ovld_nxt;
  logic [MemW-1:0]  rdata, wdata;
  logic             we;
  logic [31:0]      rd_id, rd_dly, rd_last, elapsed;
  logic             rd_once;

  assign {rd_once, rd_id, rd_dly, rd_last} = rdata;
  assign elapsed = now_r - rd_last;

  // write a new timer, or refresh the last time of one that fired
  assign we    = cmd.do_add | cmd.do_fire;
  assign wdata = cmd.do_add ? {once_r, next_id_r + 32'd1, dly_r, now_r}
                            : {rd_once, rd_id, rd_dly, now_r};

  optt_ram #(.WIDTH(MemW), .DEPTH(TASKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_comb begin
    valid_nxt   = valid_r;
    idx_nxt     = idx_r;
    next_id_nxt = next_id_r;
    ovld_nxt    = ovld_r & ~out_ready;
    if (cmd.load) idx_nxt = '0;
    if (cmd.step) idx_nxt = idx_r + IdxW'(1);
    if (cmd.do_add) begin
      valid_nxt[idx_r] = 1'b1;
      next_id_nxt      = next_id_r + 32'd1;
    end
    if (cmd.do_free) valid_nxt[idx_r] = 1'b0;
    if (cmd.do_clear) valid_nxt = '0;
    if (cmd.emit) ovld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      idx_r     <= '0;
      next_id_r <= '0;
      ovld_r    <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      idx_r     <= idx_nxt;
      next_id_r <= next_id_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  // capture the transaction and the result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_t'(in_word[1:0]);
      now_r  <= in_word[33:2];
      dly_r  <= in_word[65:34];
      once_r <= in_word[66];
      hid_r  <= in_word[98:67];
    end
    if (cmd.emit) begin
      obuf_r <= {4'd0, cmd.fin,
                 cmd.id_sel ? ((cmd.kind == K_ADDED) ? next_id_r + 32'd1 : rd_id) : 32'd0,
                 cmd.kind};
    end
  end

  assign sts.func      = func_r;
  assign sts.cur_valid = valid_r[idx_r];
  assign sts.match     = (rd_id == hid_r);
  assign sts.due       = (elapsed >= rd_dly);
  assign sts.once      = rd_once;
  assign sts.at_end    = (idx_r == IdxW'(TASKS - 1));
  assign sts.out_busy  = ovld_r;
  assign out_word      = obuf_r;
  assign out_valid     = ovld_r;

endmodule

@@ sv/optt_ctrl.sv @@
module optt_ctrl
  import optt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_DONE  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  // DONE stores the kind of frame-done or failure result; FIN emits it
  kind_t  fkind_r, fkind_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    fkind_nxt = fkind_r;
    cmd       = '0;
    cmd.kind  = K_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // clear needs no scan
        if (sts.func == FUNC_CLEAR) begin
          if (!sts.out_busy) begin
            cmd.do_clear = 1'b1;
            cmd.emit     = 1'b1;
            cmd.kind     = K_CLEARED;
            cmd.fin      = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.func == FUNC_ADD && !sts.cur_valid) begin
          if (!sts.out_busy) begin
            cmd.do_add = 1'b1;
            cmd.emit   = 1'b1;
            cmd.kind   = K_ADDED;
            cmd.id_sel = 1'b1;
            cmd.fin    = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (sts.func != FUNC_ADD && sts.cur_valid) begin
          state_nxt = S_EVAL;   // registered read lands next cycle
        end else if (sts.at_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EVAL: begin
        if (sts.func == FUNC_REMOVE) begin
          if (sts.match) begin
            if (!sts.out_busy) begin
              cmd.do_free = 1'b1;
              cmd.emit    = 1'b1;
              cmd.kind    = K_REMOVED;
              cmd.id_sel  = 1'b1;
              cmd.fin     = 1'b1;
              state_nxt   = S_IDLE;
            end
          end else if (sts.at_end) begin
            state_nxt = S_DONE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_READ;
          end
        end else if (sts.due) begin
          if (!sts.out_busy) begin
            cmd.do_fire = 1'b1;
            cmd.do_free = sts.once;
            cmd.emit    = 1'b1;
            cmd.kind    = K_FIRED;
            cmd.id_sel  = 1'b1;
            if (sts.at_end) state_nxt = S_DONE;
            else begin
              cmd.step  = 1'b1;
              state_nxt = S_READ;
            end
          end
        end else if (sts.at_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        unique case (sts.func)
          FUNC_ADD:    fkind_nxt = K_FULL;
          FUNC_REMOVE: fkind_nxt = K_NOTFOUND;
          default:     fkind_nxt = K_DONE;
        endcase
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          cmd.kind  = fkind_r;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fkind_r <= K_DONE;
    end else begin
      state_r <= state_nxt;
      fkind_r <= fkind_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy) else $error("emit into a full output register");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.fin) |=> state_r == S_IDLE) else $error("final result without idle");
  a_no_add_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_add && cmd.do_free)) else $error("add and free together");

endmodule

@@ sv/oneshot_periodic_timer_table.sv @@
// Timer table, one item at a time through a slot scan of a registered-read RAM.
// Add takes the lowest free slot or reports full; clear needs no scan.
// Remove scans to the first matching slot, frame poll scans every slot: a valid slot is read
// and then evaluated, an empty one is stepped past.
// A result still waiting in the output register holds the scan until it is taken.
// Synchronous active-low reset empties every slot and zeros the id counter; no clearing pass.
module oneshot_periodic_timer_table
  import optt_pkg::*;
#(
  parameter int unsigned TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[1:0], now_ms[33:2], delay_ms[65:34], one_shot[66], handle_id[98:67], zero pad
  input  logic [103:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // kind[2:0], task_id[34:3], zero pad
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  cmd_t        cmd;
  sts_t        sts;
  logic [39:0] word;

  optt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid & in_tready),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  optt_datapath #(.TASKS(TASKS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_tdata[98:0]),
    .out_word  (word),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = {5'd0, word[34:0]};
  assign out_tlast = word[35];

endmodule

@@ verif/oneshot_periodic_timer_table_tb.sv @@
module oneshot_periodic_timer_table_tb
  import optt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TASKS = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // packed from the lowest bit up: func, now_ms, delay_ms, one_shot, handle_id
  typedef struct packed {
    logic [31:0] handle_id;
    logic        one_shot;
    logic [31:0] delay_ms;
    logic [31:0] now_ms;
    func_t       func;
  } timer_cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] task_id;
    logic        last;
  } timer_evt_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;
  logic         out_tlast;

  oneshot_periodic_timer_table #(.TASKS(TASKS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state of the timer table
  logic        tbl_valid [TASKS];
  logic        tbl_once  [TASKS];
  logic [31:0] tbl_id    [TASKS];
  logic [31:0] tbl_delay [TASKS];
  logic [31:0] tbl_last  [TASKS];
  logic [31:0] tbl_next_id;

  timer_cmd_t pending_cmds[$];
  timer_evt_t expected_evts[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit hold_send = 1'b0;

  function automatic timer_evt_t mk_evt(kind_t k, logic [31:0] id, logic fin);
    timer_evt_t e;
    e.kind = k;
    e.task_id = id;
    e.last = fin;
    return e;
  endfunction

  // Work out the events one command causes and update the table copy
  task automatic predict_timer_events(input timer_cmd_t c);
    bit hit;
    hit = 1'b0;
    case (c.func)
      FUNC_ADD: begin
        for (int i = 0; i < TASKS; i++) begin
          if (!hit && !tbl_valid[i]) begin
            hit = 1'b1;
            tbl_next_id = tbl_next_id + 32'd1;
            tbl_valid[i] = 1'b1;
            tbl_once[i] = c.one_shot;
            tbl_id[i] = tbl_next_id;
            tbl_delay[i] = c.delay_ms;
            tbl_last[i] = c.now_ms;
            expected_evts.push_back(mk_evt(K_ADDED, tbl_next_id, 1'b1));
          end
        end
        if (!hit) expected_evts.push_back(mk_evt(K_FULL, 32'd0, 1'b1));
      end
      FUNC_REMOVE: begin
        for (int i = 0; i < TASKS; i++) begin
          if (!hit && tbl_valid[i] && tbl_id[i] == c.handle_id) begin
            hit = 1'b1;
            tbl_valid[i] = 1'b0;
            expected_evts.push_back(mk_evt(K_REMOVED, c.handle_id, 1'b1));
          end
        end
        if (!hit) expected_evts.push_back(mk_evt(K_NOTFOUND, 32'd0, 1'b1));
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < TASKS; i++) tbl_valid[i] = 1'b0;
        expected_evts.push_back(mk_evt(K_CLEARED, 32'd0, 1'b1));
      end
      default: begin
        for (int i = 0; i < TASKS; i++) begin
          if (tbl_valid[i] && (c.now_ms - tbl_last[i]) >= tbl_delay[i]) begin
            tbl_last[i] = c.now_ms;
            expected_evts.push_back(mk_evt(K_FIRED, tbl_id[i], 1'b0));
            if (tbl_once[i]) tbl_valid[i] = 1'b0;
          end
        end
        expected_evts.push_back(mk_evt(K_DONE, 32'd0, 1'b1));
      end
    endcase
  endtask

  function automatic timer_cmd_t mk_cmd(func_t f, logic [31:0] now, logic [31:0] dly,
                                        logic once, logic [31:0] hid);
    timer_cmd_t c;
    c.func = f;
    c.now_ms = now;
    c.delay_ms = dly;
    c.one_shot = once;
    c.handle_id = hid;
    return c;
  endfunction

  // Driver: present queued commands, predict on acceptance
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_timer_events(timer_cmd_t'(in_tdata[98:0]));
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() > 0 && !hold_send &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, pending_cmds.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
          in_tdata <= 104'({$urandom, $urandom, $urandom, $urandom});
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    timer_evt_t got, exp_e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = mk_evt(kind_t'(out_tdata[2:0]), out_tdata[34:3], out_tlast);
        if (expected_evts.size() == 0) begin
          $display("%0t: unexpected result, actual kind=%0d id=%h last=%b",
                   $realtime, got.kind, got.task_id, got.last);
          errors <= errors + 1;
        end else begin
          exp_e = expected_evts.pop_front();
          if (got !== exp_e) begin
            $display("%0t: mismatch, expected kind=%0d id=%h last=%b, actual kind=%0d id=%h last=%b",
                     $realtime, exp_e.kind, exp_e.task_id, exp_e.last,
                     got.kind, got.task_id, got.last);
            errors <= errors + 1;
          end
        end
      end
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL oneshot_periodic_timer_table");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_tvalid || expected_evts.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random command mostly near a small set of live ids
  function automatic timer_cmd_t rand_cmd(logic [31:0] base_now);
    int unsigned r;
    logic [31:0] dly, hid;
    r = $urandom_range(99, 0);
    dly = ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(40, 0);
    hid = ($urandom_range(4, 0) == 0) ? $urandom : tbl_next_id - $urandom_range(20, 0);
    if (r < 40)      return mk_cmd(FUNC_ADD, base_now, dly, 1'($urandom_range(1, 0)), $urandom);
    else if (r < 60) return mk_cmd(FUNC_REMOVE, $urandom, $urandom,
                                   1'($urandom_range(1, 0)), hid);
    else if (r < 63) return mk_cmd(FUNC_CLEAR, $urandom, $urandom, 1'($urandom_range(1, 0)),
                                   $urandom);
    else             return mk_cmd(FUNC_FRAME, base_now, $urandom, 1'($urandom_range(1, 0)),
                                   $urandom);
  endfunction

  initial begin
    logic [31:0] now;
    for (int i = 0; i < TASKS; i++) tbl_valid[i] = 1'b0;
    tbl_next_id = 32'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero delay, max delay, one-shot, wrap of time, full table, remove, clear
    pending_cmds.push_back(mk_cmd(FUNC_FRAME, 32'd0, 32'd0, 1'b0, 32'd0));
    pending_cmds.push_back(mk_cmd(FUNC_ADD, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(FUNC_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1, 32'd0));
    pending_cmds.push_back(mk_cmd(FUNC_ADD, 32'hFFFF_FFF0, 32'h20, 1'b1, 32'd0));
    pending_cmds.push_back(mk_cmd(FUNC_FRAME, 32'h10, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(FUNC_FRAME, 32'h10, 32'd0, 1'b0, 32'd0));
    for (int i = 0; i < 15; i++)
      pending_cmds.push_back(mk_cmd(FUNC_ADD, 32'h20, i[31:0], 1'b0, 32'd0));
    pending_cmds.push_back(mk_cmd(FUNC_REMOVE, 32'd0, 32'd0, 1'b0, 32'd1));
    pending_cmds.push_back(mk_cmd(FUNC_REMOVE, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(FUNC_FRAME, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0));
    pending_cmds.push_back(mk_cmd(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                  32'hFFFF_FFFF));
    send_idle_pct = 19;
    recv_idle_pct = 49;
    wait_drained();

    // Hold off the sender until the table has answered everything
    hold_send = 1'b1;
    wait_drained();
    hold_send = 1'b0;

    // Random phases with changing idle pressure
    now = $urandom;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 19 : 0;
      for (int n = 0; n < 48; n++) begin
        now = now + $urandom_range(15, 0);
        // build against the live predictor state: queue one and let it drain a bit
        pending_cmds.push_back(rand_cmd(now));
        while (pending_cmds.size() > 0) @(posedge clk);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS oneshot_periodic_timer_table");
    end else begin
      $display("FAIL oneshot_periodic_timer_table");
    end
    $finish;
  end

endmodule
